// ===== rtl/ssprx_pkg.sv =====
// ----------------------------------------------------------------------------
// ssprx_pkg
// Shared types and constants for the servo status packet receiver: the input
// and result beat layouts, operation codes and status codes.
// ----------------------------------------------------------------------------
package ssprx_pkg;

	// Operation carried by one input beat.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Completion status of one transaction.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TIMEOUT   = 2'd1,
		ST_BAD_ID    = 2'd2,
		ST_SERVO_ERR = 2'd3
	} status_t;

	// Header byte value; repeated header bytes at the id slot are skipped.
	localparam logic [7:0] HDR_BYTE = 8'hFF;

	// Shortest legal frame, header included.
	localparam logic [4:0] MIN_FRAME_BYTES = 5'd6;

	// Frame positions of the fields that the result uses.
	localparam int POS_ID    = 2;
	localparam int POS_ERR   = 4;
	localparam int POS_VAL_L = 5;
	localparam int POS_VAL_H = 6;

	// Shortest frame that carries a read value.
	localparam int VALUE_FRAME_BYTES = 8;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] expected_id;
		logic [3:0] expected_length;
		logic [7:0] rx_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status_code;
		logic [7:0]  servo_error;
		logic [15:0] read_value;
	} out_beat_t;

	// Transaction status exported by the frame core.
	typedef struct packed {
		logic active;
		logic bad_id_seen;
	} core_stat_t;

endpackage

// ===== rtl/servo_status_packet_receiver_core.sv =====
// ----------------------------------------------------------------------------
// servo_status_packet_receiver_core
// Flow: a beat accepted into the input register is processed by the frame core
//   once the result register can load; its result is then registered and offered on out_valid.
// Throughput: one input beat per cycle while the result register can load,
//   set by the single-pass frame core between the input and result registers.
// Reset: arst_n clears the transaction to idle and timeout_ticks to 100.
// ----------------------------------------------------------------------------
module servo_status_packet_receiver_core
	import ssprx_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_beat,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_beat,
	input  logic        cfg_write_enable,
	input  logic [15:0] cfg_write_data
);

	logic       in_valid_s1;
	in_beat_t   in_beat_s1;
	logic       out_valid_q;
	out_beat_t  out_beat_q;
	logic [15:0] timeout_ticks_q;

	logic       out_free;
	logic       fire_s1;
	logic       res_valid;
	out_beat_t  result;
	core_stat_t core_stat;

	// The result register can load when empty or being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = in_valid_s1 && out_free;
	assign in_stall = in_valid_s1 && !out_free;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= 16'd100;
		end else if (cfg_write_enable) begin
			timeout_ticks_q <= cfg_write_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_beat_s1 <= in_beat;
		end
	end

	ssprx_frame_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_frame_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire_s1),
		.item         (in_beat_s1),
		.timeout_ticks(timeout_ticks_q),
		.res_valid    (res_valid),
		.result       (result),
		.stat         (core_stat)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_beat_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	// A result always closes the transaction.
	a_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !core_stat.active)
		else $error("transaction still active after a result");

	// An idle receiver produces no result.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !core_stat.active) |-> !res_valid)
		else $error("result produced while idle");

	// A bad-id status requires a discarded frame in this transaction.
	a_bad_id_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && result.status_code == ST_BAD_ID) |-> core_stat.bad_id_seen)
		else $error("bad id reported without a mismatched frame");

	// Input stalls only when the input register holds an unprocessed beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (in_valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked beat");

endmodule

// ===== rtl/ssprx_frame_core.sv =====
// ----------------------------------------------------------------------------
// ssprx_frame_core
// Transaction state and frame parser. Processes one registered input beat
// per cycle when fire is high and produces at most one result.
// ----------------------------------------------------------------------------
module ssprx_frame_core
	import ssprx_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  in_beat_t   item,
	input  logic [15:0] timeout_ticks,
	output logic       res_valid,
	output out_beat_t  result,
	output core_stat_t stat
);

	localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IDX_W  = $clog2(MAX_FRAME_BYTES);
	localparam int VIEW_N = (MAX_FRAME_BYTES < VALUE_FRAME_BYTES) ?
		VALUE_FRAME_BYTES : MAX_FRAME_BYTES;
	localparam bit LONG_OK = (MAX_FRAME_BYTES >= VALUE_FRAME_BYTES);

	logic             active_q;
	logic [CNT_W-1:0] byte_index_q;
	logic [7:0]       frame_q [MAX_FRAME_BYTES];
	logic [7:0]       want_id_q;
	logic [CNT_W-1:0] want_length_q;
	logic [15:0]      elapsed_q;
	logic             bad_id_seen_q;

	logic             active_d;
	logic [CNT_W-1:0] byte_index_d;
	logic [7:0]       want_id_d;
	logic [CNT_W-1:0] want_length_d;
	logic [15:0]      elapsed_d;
	logic             bad_id_seen_d;
	logic             frame_clr;
	logic             frame_wr;

	logic [7:0]       view [VIEW_N];
	logic [4:0]       len_ext;
	logic [4:0]       len_clamp;
	logic [16:0]      tick_next;
	logic [CNT_W-1:0] idx_next;
	logic             want_long;

	// Frame as it stands with the current byte written at the current index.
	for (genvar k = 0; k < VIEW_N; k++) begin : g_view
		if (k < MAX_FRAME_BYTES) begin : g_real
			assign view[k] = (byte_index_q == CNT_W'(k)) ? item.rx_byte : frame_q[k];
		end else begin : g_pad
			assign view[k] = 8'h00;
		end
	end

	// Clamp the requested frame length into the legal range.
	assign len_ext   = {1'b0, item.expected_length};
	assign len_clamp = (len_ext < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES :
		(len_ext > 5'(MAX_FRAME_BYTES)) ? 5'(MAX_FRAME_BYTES) : len_ext;

	assign tick_next = {1'b0, elapsed_q} + 17'd1;
	assign idx_next  = byte_index_q + CNT_W'(1);
	assign want_long = LONG_OK && (want_length_q >= CNT_W'(VALUE_FRAME_BYTES));

	// Next state and result for the beat being processed.
	always_comb begin
		active_d      = active_q;
		byte_index_d  = byte_index_q;
		want_id_d     = want_id_q;
		want_length_d = want_length_q;
		elapsed_d     = elapsed_q;
		bad_id_seen_d = bad_id_seen_q;
		frame_clr     = 1'b0;
		frame_wr      = 1'b0;
		res_valid     = 1'b0;
		result        = '0;
		case (op_t'(item.operation))
			OP_START: begin
				active_d      = 1'b1;
				byte_index_d  = '0;
				frame_clr     = 1'b1;
				want_id_d     = item.expected_id;
				want_length_d = CNT_W'(len_clamp);
				elapsed_d     = '0;
				bad_id_seen_d = 1'b0;
			end
			OP_TICK: begin
				if (active_q) begin
					if (tick_next > {1'b0, timeout_ticks}) begin
						active_d  = 1'b0;
						res_valid = 1'b1;
						result.status_code = bad_id_seen_q ? ST_BAD_ID : ST_TIMEOUT;
					end else begin
						elapsed_d = tick_next[15:0];
					end
				end
			end
			OP_BYTE: begin
				if (active_q) begin
					if (byte_index_q == CNT_W'(0)) begin
						if (item.rx_byte == HDR_BYTE) begin
							frame_wr     = 1'b1;
							byte_index_d = CNT_W'(1);
						end
					end else if (byte_index_q == CNT_W'(1)) begin
						if (item.rx_byte == HDR_BYTE) begin
							frame_wr     = 1'b1;
							byte_index_d = CNT_W'(2);
						end else begin
							byte_index_d = '0;
						end
					end else if (!(byte_index_q == CNT_W'(2) && item.rx_byte == HDR_BYTE))
					begin
						frame_wr     = 1'b1;
						byte_index_d = idx_next;
						if (idx_next >= want_length_q) begin
							byte_index_d = '0;
							if (view[POS_ID] == want_id_q) begin
								// Matching frame closes the transaction.
								active_d = 1'b0;
								res_valid = 1'b1;
								result.servo_error = view[POS_ERR];
								if (view[POS_ERR] == 8'h00) begin
									result.status_code = ST_OK;
									if (want_long) begin
										result.read_value = {view[POS_VAL_H], view[POS_VAL_L]};
									end
								end else begin
									result.status_code = ST_SERVO_ERR;
								end
							end else begin
								// Wrong id: drop the frame and hunt again.
								bad_id_seen_d = 1'b1;
								frame_clr     = 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (!fire) begin
			res_valid = 1'b0;
		end
	end

	// Transaction state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			byte_index_q  <= '0;
			want_id_q     <= '0;
			want_length_q <= '0;
			elapsed_q     <= '0;
			bad_id_seen_q <= 1'b0;
		end else if (fire) begin
			active_q      <= active_d;
			byte_index_q  <= byte_index_d;
			want_id_q     <= want_id_d;
			want_length_q <= want_length_d;
			elapsed_q     <= elapsed_d;
			bad_id_seen_q <= bad_id_seen_d;
		end
	end

	// Frame byte store, cleared on start and on a discarded frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
				frame_q[i] <= 8'h00;
			end
		end else if (fire) begin
			if (frame_clr) begin
				for (int i = 0; i < MAX_FRAME_BYTES; i++) begin
					frame_q[i] <= 8'h00;
				end
			end else if (frame_wr && (byte_index_q < CNT_W'(MAX_FRAME_BYTES))) begin
				frame_q[byte_index_q[IDX_W-1:0]] <= item.rx_byte;
			end
		end
	end

	assign stat.active      = active_q;
	assign stat.bad_id_seen = bad_id_seen_q;

endmodule
